>>> rtl/msgpack_token_reader_core_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef MSGPACK_TOKEN_READER_CORE_DEFINES_SVH
`define MSGPACK_TOKEN_READER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define MTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/mtr_pkg.sv
`default_nettype none

package mtr_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_VALUE,
    PH_LENGTH,
    PH_EXTTYPE,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [3:0] {
    K_NIL   = 4'd0,
    K_BOOL  = 4'd1,
    K_UINT  = 4'd2,
    K_SINT  = 4'd3,
    K_FLOAT = 4'd4,
    K_STR   = 4'd5,
    K_BIN   = 4'd6,
    K_EXT   = 4'd7,
    K_ARRAY = 4'd8,
    K_MAP   = 4'd9,
    K_CHUNK = 4'd10,
    K_ERROR = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_EMIT,
    OP_VBYTE
  } op_e;

  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [32:0] length;
    logic [3:0]  width;
    logic [7:0]  data;
    logic        first;
    logic        last;
  } uop_t;

  typedef struct packed {
    phase_e     phase;
    kind_e      kind;
    logic [3:0] width;
    logic       emit;
    logic [5:0] length;
    logic [7:0] data;
  } hdr_t;

  function automatic hdr_t decode_header(logic [7:0] t);
    hdr_t       h;
    logic [7:0] off;
    h       = '{phase: PH_HEADER, kind: K_NIL, width: 4'd0, emit: 1'b0,
                length: 6'd0, data: 8'd0};
    off     = 8'd0;
    if (t < 8'h80) begin
      h.emit   = 1'b1;
      h.kind   = K_UINT;
      h.length = 6'd1;
      h.data   = t;
    end else if (t < 8'h90) begin
      h.emit   = 1'b1;
      h.kind   = K_MAP;
      h.length = {1'b0, t[3:0], 1'b0};
    end else if (t < 8'ha0) begin
      h.emit   = 1'b1;
      h.kind   = K_ARRAY;
      h.length = {2'b00, t[3:0]};
    end else if (t < 8'hc0) begin
      h.emit   = 1'b1;
      h.kind   = K_STR;
      h.length = {1'b0, t[4:0]};
      if (t[4:0] != 5'd0) begin
        h.phase = PH_PAYLOAD;
      end
    end else if (t >= 8'he0) begin
      h.emit   = 1'b1;
      h.kind   = K_SINT;
      h.length = 6'd1;
      h.data   = t;
    end else if (t == 8'hc0) begin
      h.emit = 1'b1;
      h.kind = K_NIL;
    end else if (t == 8'hc1) begin
      h.emit = 1'b1;
      h.kind = K_ERROR;
    end else if (t <= 8'hc3) begin
      h.emit   = 1'b1;
      h.kind   = K_BOOL;
      h.length = 6'd1;
      h.data   = {7'd0, t[0]};
    end else if (t <= 8'hc6) begin
      h.phase = PH_LENGTH;
      h.kind  = K_BIN;
      h.width = 4'd1 << t[1:0];
    end else if (t <= 8'hc9) begin
      off     = t - 8'hc7;
      h.phase = PH_LENGTH;
      h.kind  = K_EXT;
      h.width = 4'd1 << off[1:0];
    end else if (t <= 8'hcb) begin
      h.phase = PH_VALUE;
      h.kind  = K_FLOAT;
      h.width = t[0] ? 4'd8 : 4'd4;
    end else if (t <= 8'hcf) begin
      h.phase = PH_VALUE;
      h.kind  = K_UINT;
      h.width = 4'd1 << t[1:0];
    end else if (t <= 8'hd3) begin
      h.phase = PH_VALUE;
      h.kind  = K_SINT;
      h.width = 4'd1 << t[1:0];
    end else if (t <= 8'hd8) begin
      off      = t - 8'hd4;
      h.phase  = PH_EXTTYPE;
      h.kind   = K_EXT;
      h.length = 6'd1 << off[2:0];
    end else if (t <= 8'hdb) begin
      off     = t - 8'hd9;
      h.phase = PH_LENGTH;
      h.kind  = K_STR;
      h.width = 4'd1 << off[1:0];
    end else if (t <= 8'hdd) begin
      h.phase = PH_LENGTH;
      h.kind  = K_ARRAY;
      h.width = 4'd2 << t[0];
    end else begin
      h.phase = PH_LENGTH;
      h.kind  = K_MAP;
      h.width = 4'd2 << t[0];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mtr_front.sv
`default_nettype none

module mtr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          fifo_full_i,
  output logic               push_o,
  output mtr_pkg::uop_t      uop_o
);
  import mtr_pkg::*;

  phase_e      phase_q, phase_d;
  kind_e       pend_kind_q, pend_kind_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [3:0]  width_q, width_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] ext_len_q, ext_len_d;
  logic [31:0] payload_left_q, payload_left_d;

  logic        accept;
  hdr_t        hdr;
  logic        field_end;
  logic [31:0] len_new;
  logic [3:0]  bytes_dec;
  logic [31:0] payload_dec;

  assign accept      = in_valid_i && !fifo_full_i;
  assign hdr         = decode_header(data_byte_i);
  assign field_end   = (bytes_left_q <= 4'd1);
  assign len_new     = {len_acc_q[23:0], data_byte_i};
  assign bytes_dec   = (bytes_left_q != 4'd0) ? bytes_left_q - 4'd1 : 4'd0;
  assign payload_dec = (payload_left_q != 32'd0) ? payload_left_q - 32'd1 : 32'd0;

  always_comb begin
    phase_d        = phase_q;
    pend_kind_d    = pend_kind_q;
    bytes_left_d   = bytes_left_q;
    width_d        = width_q;
    len_acc_d      = len_acc_q;
    ext_len_d      = ext_len_q;
    payload_left_d = payload_left_q;
    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          phase_d = hdr.phase;
          if (hdr.phase inside {PH_VALUE, PH_LENGTH}) begin
            pend_kind_d  = hdr.kind;
            bytes_left_d = hdr.width;
            width_d      = hdr.width;
            len_acc_d    = 32'd0;
          end
          if (hdr.phase == PH_EXTTYPE) begin
            ext_len_d = {26'd0, hdr.length};
          end
          if (hdr.phase == PH_PAYLOAD) begin
            payload_left_d = {26'd0, hdr.length};
          end
        end
        PH_VALUE: begin
          bytes_left_d = bytes_dec;
          if (field_end) begin
            phase_d = PH_HEADER;
          end
        end
        PH_LENGTH: begin
          len_acc_d    = len_new;
          bytes_left_d = bytes_dec;
          if (field_end) begin
            phase_d = PH_HEADER;
            if (pend_kind_q == K_EXT) begin
              ext_len_d = len_new;
              phase_d   = PH_EXTTYPE;
            end else if ((pend_kind_q inside {K_STR, K_BIN}) && (len_new != 32'd0)) begin
              payload_left_d = len_new;
              phase_d        = PH_PAYLOAD;
            end
          end
        end
        PH_EXTTYPE: begin
          if (ext_len_q != 32'd0) begin
            payload_left_d = ext_len_q;
            phase_d        = PH_PAYLOAD;
          end else begin
            phase_d = PH_HEADER;
          end
        end
        PH_PAYLOAD: begin
          payload_left_d = payload_dec;
          if (payload_dec == 32'd0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    uop_o = '{op: OP_NONE, kind: K_NIL, length: 33'd0, width: width_q,
              data: data_byte_i, first: 1'b0, last: 1'b0};
    case (phase_q)
      PH_HEADER: begin
        if (hdr.emit) begin
          uop_o.op     = OP_EMIT;
          uop_o.kind   = hdr.kind;
          uop_o.length = {27'd0, hdr.length};
          uop_o.data   = hdr.data;
        end
      end
      PH_VALUE: begin
        uop_o.op    = OP_VBYTE;
        uop_o.kind  = pend_kind_q;
        uop_o.first = (bytes_left_q == width_q);
        uop_o.last  = field_end;
      end
      PH_LENGTH: begin
        if (field_end && (pend_kind_q != K_EXT)) begin
          uop_o.op     = OP_EMIT;
          uop_o.kind   = pend_kind_q;
          uop_o.length = (pend_kind_q == K_MAP) ? {len_new, 1'b0} : {1'b0, len_new};
          uop_o.data   = 8'd0;
        end
      end
      PH_EXTTYPE: begin
        uop_o.op     = OP_EMIT;
        uop_o.kind   = K_EXT;
        uop_o.length = {1'b0, ext_len_q};
      end
      PH_PAYLOAD: begin
        uop_o.op     = OP_EMIT;
        uop_o.kind   = K_CHUNK;
        uop_o.length = 33'd1;
        uop_o.last   = (payload_dec == 32'd0);
      end
      default: begin
        uop_o.op = OP_NONE;
      end
    endcase
  end

  assign push_o = accept && (uop_o.op != OP_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      pend_kind_q    <= K_NIL;
      bytes_left_q   <= 4'd0;
      width_q        <= 4'd0;
      len_acc_q      <= 32'd0;
      ext_len_q      <= 32'd0;
      payload_left_q <= 32'd0;
    end else begin
      phase_q        <= phase_d;
      pend_kind_q    <= pend_kind_d;
      bytes_left_q   <= bytes_left_d;
      width_q        <= width_d;
      len_acc_q      <= len_acc_d;
      ext_len_q      <= ext_len_d;
      payload_left_q <= payload_left_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mtr_fifo.sv
`default_nettype none

module mtr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mtr_pkg::uop_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               pop_valid_o,
  output mtr_pkg::uop_t      pop_data_o
);
  import mtr_pkg::*;

  uop_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o = (count_q != (FIFO_AW+1)'(0));
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mtr_back.sv
`default_nettype none

module mtr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          uop_valid_i,
  input  wire mtr_pkg::uop_t uop_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [3:0]         token_kind_o,
  output logic [32:0]        token_length_o,
  output logic [63:0]        token_value_o,
  output logic [7:0]         ext_code_o,
  output logic [7:0]         chunk_data_o,
  output logic               chunk_last_o
);
  import mtr_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [32:0] length_q, length_d;
  logic [63:0] value_q, value_d;
  logic [7:0]  ext_q, ext_d;
  logic [7:0]  chunk_q, chunk_d;
  logic        last_q, last_d;
  logic        res_valid;
  logic        ready;
  logic        sign_bit;

  assign ready = !out_valid_q || !out_stall_i;
  assign pop_o = ready && uop_valid_i;

  always_comb begin
    acc_d = acc_q;
    if (pop_o && (uop_i.op == OP_VBYTE)) begin
      acc_d = uop_i.first ? {56'd0, uop_i.data} : {acc_q[55:0], uop_i.data};
    end
  end

  always_comb begin
    case (uop_i.width)
      4'd1:    sign_bit = acc_d[7];
      4'd2:    sign_bit = acc_d[15];
      4'd4:    sign_bit = acc_d[31];
      4'd8:    sign_bit = acc_d[63];
      default: sign_bit = 1'b1;
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    kind_d    = uop_i.kind;
    length_d  = uop_i.length;
    value_d   = 64'd0;
    ext_d     = 8'd0;
    chunk_d   = 8'd0;
    last_d    = 1'b0;
    case (uop_i.op)
      OP_VBYTE: begin
        res_valid = uop_i.last;
        length_d  = {29'd0, uop_i.width};
        value_d   = acc_d;
        if ((uop_i.kind == K_SINT) && !sign_bit) begin
          kind_d = K_UINT;
        end
      end
      OP_EMIT: begin
        res_valid = 1'b1;
        if (uop_i.kind inside {K_UINT, K_SINT, K_BOOL}) begin
          value_d = {56'd0, uop_i.data};
        end
        if (uop_i.kind == K_EXT) begin
          ext_d = uop_i.data;
        end
        if (uop_i.kind == K_CHUNK) begin
          chunk_d = uop_i.data;
          last_d  = uop_i.last;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign out_valid_d = ready ? (pop_o && res_valid) : out_valid_q;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ready && pop_o && res_valid) begin
      kind_q   <= kind_d;
      length_q <= length_d;
      value_q  <= value_d;
      ext_q    <= ext_d;
      chunk_q  <= chunk_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = kind_q;
  assign token_length_o = length_q;
  assign token_value_o  = value_q;
  assign ext_code_o     = ext_q;
  assign chunk_data_o   = chunk_q;
  assign chunk_last_o   = last_q;

endmodule

`default_nettype wire

>>> rtl/msgpack_token_reader_core.sv
// Channel   Valid        Stall         Payload
// input     in_valid_i   in_stall_o    data_byte_i
// output    out_valid_o  out_stall_i   token_kind_o, token_length_o, token_value_o,
//                                      ext_code_o, chunk_data_o, chunk_last_o
//
// One byte is accepted per cycle while the input is not stalled.
// The front parser classifies each byte and feeds a two-entry queue that the
// back end drains into the output register at one entry per cycle while the output is not stalled.
// The input stalls only while that queue is full; the output holds while stalled.
// Reset is asynchronous and active low and returns the parser to the header state.
`default_nettype none

module msgpack_token_reader_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       token_kind_o,
  output logic [32:0]      token_length_o,
  output logic [63:0]      token_value_o,
  output logic [7:0]       ext_code_o,
  output logic [7:0]       chunk_data_o,
  output logic             chunk_last_o
);
  import mtr_pkg::*;

  logic fifo_full;
  logic push;
  uop_t push_uop;
  logic pop;
  logic pop_valid;
  uop_t pop_uop;

  assign in_stall_o = fifo_full;

  mtr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .uop_o       (push_uop)
  );

  mtr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_uop),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_uop)
  );

  mtr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .uop_valid_i    (pop_valid),
    .uop_i          (pop_uop),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_length_o (token_length_o),
    .token_value_o  (token_value_o),
    .ext_code_o     (ext_code_o),
    .chunk_data_o   (chunk_data_o),
    .chunk_last_o   (chunk_last_o)
  );

endmodule

`default_nettype wire

>>> rtl/mtr_checker.sv
`default_nettype none

`include "msgpack_token_reader_core_defines.svh"

module mtr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  data_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  token_kind_o,
  input wire logic [32:0] token_length_o,
  input wire logic [63:0] token_value_o,
  input wire logic [7:0]  ext_code_o,
  input wire logic [7:0]  chunk_data_o,
  input wire logic        chunk_last_o
);
  import mtr_pkg::*;

  // A stalled transaction stays on the output with its kind, value and length unchanged.
  `MTR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(token_kind_o) && $stable(token_value_o) && $stable(token_length_o))
  `MTR_ASSERT_IMP(a_error_clean, clk_i, rst_ni, out_valid_o && (token_kind_o == K_ERROR), (token_length_o == 33'd0) && (token_value_o == 64'd0) && (ext_code_o == 8'd0) && (chunk_data_o == 8'd0) && !chunk_last_o)
  `MTR_ASSERT_IMP(a_last_is_chunk, clk_i, rst_ni, out_valid_o && chunk_last_o, (token_kind_o == K_CHUNK) && (token_length_o == 33'd1))
  `MTR_ASSERT_IMP(a_map_even, clk_i, rst_ni, out_valid_o && (token_kind_o == K_MAP), !token_length_o[0])

endmodule

bind msgpack_token_reader_core mtr_checker u_mtr_checker (.*);

`default_nettype wire
